// ===== rtl/core/pthtrk_pkg.sv =====
// Shared types, constants and preset tables of the pan/tilt head tracker.
package pthtrk_pkg;

   localparam int YawWidth    = 10;
   localparam int PitchWidth  = 7;
   localparam int BearWidth   = 10;
   localparam int RangeWidth  = 16;
   localparam int DbWidth     = 9;
   localparam int ThrWidth    = 15;
   localparam int ModeWidth   = 4;
   localparam int CsrIdxWidth = 2;

   // Wide enough for yaw plus a full-scale bearing before clamping.
   localparam int SumWidth    = 12;

   typedef logic signed [YawWidth-1:0]  yaw_type;
   typedef logic [PitchWidth-1:0]       pitch_type;
   typedef logic signed [BearWidth-1:0] bearing_type;
   typedef logic signed [RangeWidth-1:0] range_type;
   typedef logic signed [SumWidth-1:0]  sum_type;

   localparam sum_type   YawLimitH = sum_type'(270);
   localparam sum_type   YawLimitB = sum_type'(260);
   localparam sum_type   StepH     = sum_type'(2);
   localparam sum_type   StepB     = sum_type'(1);
   localparam pitch_type PitchFar  = pitch_type'(50);
   localparam pitch_type PitchNear = pitch_type'(120);

   typedef enum logic [ModeWidth-1:0] {
      MODE_FAR_LEFT         = 4'd0,
      MODE_FAR_MID          = 4'd1,
      MODE_FAR_RIGHT        = 4'd2,
      MODE_FAR_RIGHT_BACK   = 4'd3,
      MODE_FAR_LEFT_BACK    = 4'd4,
      MODE_CLOSE_LEFT       = 4'd5,
      MODE_CLOSE_MID        = 4'd6,
      MODE_CLOSE_RIGHT      = 4'd7,
      MODE_CLOSE_RIGHT_BACK = 4'd8,
      MODE_CLOSE_LEFT_BACK  = 4'd9,
      MODE_TRACK_HORIZ      = 4'd10,
      MODE_TRACK_VERT       = 4'd11,
      MODE_TRACK_BOTH       = 4'd12
   } mode_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEADBAND  = 2'd0,
      CSR_FAR_RANGE = 2'd1,
      CSR_NEAR_RANGE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DbWidth-1:0]  deadband;
      logic [ThrWidth-1:0] far_range_mm;
      logic [ThrWidth-1:0] near_range_mm;
   } cfg_type;

   localparam logic [DbWidth-1:0]  DeadbandReset  = DbWidth'(20);
   localparam logic [ThrWidth-1:0] FarRangeReset  = ThrWidth'(1200);
   localparam logic [ThrWidth-1:0] NearRangeReset = ThrWidth'(1000);

   // Preset yaw for the fixed poses; only preset modes reach here.
   function automatic yaw_type preset_yaw(input logic [ModeWidth-1:0] mode);
      yaw_type y;
      unique case (mode)
         MODE_FAR_LEFT, MODE_CLOSE_LEFT:             y = yaw_type'(180);
         MODE_FAR_MID, MODE_CLOSE_MID:               y = yaw_type'(0);
         MODE_FAR_RIGHT, MODE_CLOSE_RIGHT:           y = yaw_type'(-180);
         MODE_FAR_RIGHT_BACK, MODE_CLOSE_RIGHT_BACK: y = yaw_type'(-270);
         MODE_FAR_LEFT_BACK, MODE_CLOSE_LEFT_BACK:   y = yaw_type'(270);
         default:                                    y = yaw_type'(0);
      endcase
      return y;
   endfunction

   function automatic pitch_type preset_pitch(input logic [ModeWidth-1:0] mode);
      pitch_type p;
      unique case (mode)
         MODE_FAR_LEFT, MODE_FAR_MID, MODE_FAR_RIGHT,
         MODE_FAR_RIGHT_BACK, MODE_FAR_LEFT_BACK:    p = pitch_type'(50);
         MODE_CLOSE_MID:                             p = pitch_type'(120);
         MODE_CLOSE_LEFT, MODE_CLOSE_RIGHT,
         MODE_CLOSE_RIGHT_BACK, MODE_CLOSE_LEFT_BACK: p = pitch_type'(110);
         default:                                    p = pitch_type'(0);
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/core/pan_tilt_head_tracker_top.sv =====
// Top level of the pan/tilt head tracker: ports, pose state and result register.
//
//  channel  | ports          | direction | content
//  ---------+----------------+-----------+------------------------------------------
//  request  | req_t*         | in        | one control tick: mode, flags, bearing, range
//  response | rsp_t*         | out       | new yaw, pitch and the snap-consumed flag
//  config   | csr_*          | in        | deadband, far and near range thresholds
//
// The pose update is computed from the incoming item and the stored pose in a single
// pass and lands in the result register at the accept edge, so items may arrive back
// to back while the response side keeps taking results, presented from that register.
// The result register frees itself in the same cycle it is taken, so a stalled
// response holds only the one waiting result and blocks the request side only then.
// Synchronous reset clears the pose to zero, the thresholds to their defaults and
// empties the result register.
module pan_tilt_head_tracker_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [9:0] ball_bearing, [25:10] ball_range_mm, [26] snap_request, [31:27] zero
   input  logic [31:0] req_tdata,
   // [3:0] head_mode, [4] ball_seen
   input  logic [4:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [9:0] yaw, [16:10] pitch, [17] snap_consumed, [23:18] zero
   output logic [23:0] rsp_tdata,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   pthtrk_pkg::cfg_type   cfg_ff;
   pthtrk_pkg::yaw_type   yaw_ff;
   pthtrk_pkg::pitch_type pitch_ff;
   logic                  out_valid_ff;
   logic                  out_consumed_ff;

   pthtrk_pkg::yaw_type   yaw_in;
   pthtrk_pkg::pitch_type pitch_in;
   logic                  consumed_in;
   logic                  req_take;

   // The result register doubles as the stored pose: it always holds the latest one.
   assign req_tready = !out_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   pthtrk_step u_step (
      .head_mode     (req_tuser[3:0]),
      .ball_seen     (req_tuser[4]),
      .ball_bearing  (signed'(req_tdata[9:0])),
      .ball_range_mm (signed'(req_tdata[25:10])),
      .snap_request  (req_tdata[26]),
      .cfg           (cfg_ff),
      .yaw_cur       (yaw_ff),
      .pitch_cur     (pitch_ff),
      .yaw_next      (yaw_in),
      .pitch_next    (pitch_in),
      .snap_consumed (consumed_in)
   );

   // Configuration writes; an index past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband      <= pthtrk_pkg::DeadbandReset;
         cfg_ff.far_range_mm  <= pthtrk_pkg::FarRangeReset;
         cfg_ff.near_range_mm <= pthtrk_pkg::NearRangeReset;
      end else if (csr_we) begin
         unique case (csr_index)
            pthtrk_pkg::CSR_DEADBAND:
               cfg_ff.deadband <= csr_wdata[pthtrk_pkg::DbWidth-1:0];
            pthtrk_pkg::CSR_FAR_RANGE:   cfg_ff.far_range_mm  <= csr_wdata;
            pthtrk_pkg::CSR_NEAR_RANGE:  cfg_ff.near_range_mm <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff          <= '0;
         pitch_ff        <= '0;
         out_consumed_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (req_take) begin
            yaw_ff          <= yaw_in;
            pitch_ff        <= pitch_in;
            out_consumed_ff <= consumed_in;
            out_valid_ff    <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_consumed_ff, pitch_ff, yaw_ff};

endmodule

// ===== rtl/core/pthtrk_step.sv =====
// Next head pose from one item, the stored pose and the configuration.
module pthtrk_step (
   input  logic [pthtrk_pkg::ModeWidth-1:0] head_mode,
   input  logic                             ball_seen,
   input  pthtrk_pkg::bearing_type          ball_bearing,
   input  pthtrk_pkg::range_type            ball_range_mm,
   input  logic                             snap_request,
   input  pthtrk_pkg::cfg_type              cfg,
   input  pthtrk_pkg::yaw_type              yaw_cur,
   input  pthtrk_pkg::pitch_type            pitch_cur,
   output pthtrk_pkg::yaw_type              yaw_next,
   output pthtrk_pkg::pitch_type            pitch_next,
   output logic                             snap_consumed
);

   localparam int CmpWidth = pthtrk_pkg::BearWidth + 1;
   localparam int RngWidth = pthtrk_pkg::RangeWidth + 1;

   logic signed [CmpWidth-1:0] bear_x;
   logic signed [CmpWidth-1:0] db_pos;
   logic signed [CmpWidth-1:0] db_neg;
   logic                       step_up;
   logic                       step_dn;
   logic signed [RngWidth-1:0] range_x;
   logic signed [RngWidth-1:0] far_x;
   logic signed [RngWidth-1:0] near_x;
   logic                       is_far;
   logic                       is_near;
   pthtrk_pkg::sum_type        yaw_x;
   pthtrk_pkg::sum_type        sum_h;
   pthtrk_pkg::sum_type        sum_b;
   pthtrk_pkg::sum_type        clamp_h;
   pthtrk_pkg::sum_type        clamp_b;

   always_comb begin
      bear_x  = CmpWidth'(ball_bearing);
      db_pos  = signed'({2'b00, cfg.deadband});
      db_neg  = -db_pos;
      step_up = ball_seen && (bear_x > db_pos);
      step_dn = ball_seen && (bear_x < db_neg);

      range_x = RngWidth'(ball_range_mm);
      far_x   = signed'({2'b00, cfg.far_range_mm});
      near_x  = signed'({2'b00, cfg.near_range_mm});
      is_far  = ball_seen && (range_x > far_x);
      is_near = ball_seen && !ball_range_mm[pthtrk_pkg::RangeWidth-1] && (range_x <= near_x);

      yaw_x = pthtrk_pkg::SumWidth'(yaw_cur);

      // Horizontal track: one degree a tick outside the deadband.
      if (step_up) begin
         sum_h = yaw_x + pthtrk_pkg::StepH;
      end else if (step_dn) begin
         sum_h = yaw_x - pthtrk_pkg::StepH;
      end else begin
         sum_h = yaw_x;
      end

      // Both track: a snap jumps by the whole bearing, otherwise half a degree.
      if (snap_request) begin
         sum_b = yaw_x + pthtrk_pkg::SumWidth'(ball_bearing);
      end else if (step_up) begin
         sum_b = yaw_x + pthtrk_pkg::StepB;
      end else if (step_dn) begin
         sum_b = yaw_x - pthtrk_pkg::StepB;
      end else begin
         sum_b = yaw_x;
      end

      if (sum_h > pthtrk_pkg::YawLimitH) begin
         clamp_h = pthtrk_pkg::YawLimitH;
      end else if (sum_h < -pthtrk_pkg::YawLimitH) begin
         clamp_h = -pthtrk_pkg::YawLimitH;
      end else begin
         clamp_h = sum_h;
      end

      if (sum_b > pthtrk_pkg::YawLimitB) begin
         clamp_b = pthtrk_pkg::YawLimitB;
      end else if (sum_b < -pthtrk_pkg::YawLimitB) begin
         clamp_b = -pthtrk_pkg::YawLimitB;
      end else begin
         clamp_b = sum_b;
      end
   end

   always_comb begin
      yaw_next      = yaw_cur;
      pitch_next    = pitch_cur;
      snap_consumed = 1'b0;
      if (head_mode < pthtrk_pkg::ModeWidth'(pthtrk_pkg::MODE_TRACK_HORIZ)) begin
         yaw_next   = pthtrk_pkg::preset_yaw(head_mode);
         pitch_next = pthtrk_pkg::preset_pitch(head_mode);
      end else if (head_mode == pthtrk_pkg::ModeWidth'(pthtrk_pkg::MODE_TRACK_HORIZ)) begin
         yaw_next = pthtrk_pkg::YawWidth'(clamp_h);
      end else if (head_mode == pthtrk_pkg::ModeWidth'(pthtrk_pkg::MODE_TRACK_BOTH)) begin
         yaw_next      = pthtrk_pkg::YawWidth'(clamp_b);
         snap_consumed = snap_request;
         // Far wins where the two thresholds overlap.
         if (is_far) begin
            pitch_next = pthtrk_pkg::PitchFar;
         end else if (is_near) begin
            pitch_next = pthtrk_pkg::PitchNear;
         end
      end
   end

endmodule

// ===== dv/pan_tilt_head_tracker_checker.sv =====
// Checker for the pan/tilt head tracker: predicts every pose update and compares each result.
`timescale 1ns / 1ps
module pan_tilt_head_tracker_checker
   import pthtrk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // [9:0] ball_bearing, [25:10] ball_range_mm, [26] snap_request, [31:27] zero
   input  logic [31:0] req_tdata,
   // [3:0] head_mode, [4] ball_seen
   input  logic [4:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [9:0] yaw, [16:10] pitch, [17] snap_consumed, [23:18] zero
   input  logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_count,
   output int          results_checked,
   output int          snaps_applied,
   output int          limit_hits
);

   localparam int HorizYawLimit = 270;
   localparam int BothYawLimit  = 260;
   localparam int HorizStep     = 2;
   localparam int BothStep      = 1;
   localparam int FarPitch      = 50;
   localparam int NearPitch     = 120;

   // Laid out so that a cast of rsp_tdata lands yaw in the lowest bits.
   typedef struct packed {
      logic [5:0] pad;
      logic       snap_consumed;
      pitch_type  pitch;
      yaw_type    yaw;
   } pose_result_type;

   pose_result_type expected_poses[$];

   yaw_type             pose_yaw;
   pitch_type           pose_pitch;
   logic [DbWidth-1:0]  cfg_deadband;
   logic [ThrWidth-1:0] cfg_far_mm;
   logic [ThrWidth-1:0] cfg_near_mm;

   initial begin
      mismatch_count  = 0;
      pending_count   = 0;
      results_checked = 0;
      snaps_applied   = 0;
      limit_hits      = 0;
   end

   function automatic int limit_yaw(input int v, input int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Tracking only moves the head once the bearing leaves the deadband.
   function automatic int bearing_step(input int bearing, input logic seen, input int step);
      if (!seen) return 0;
      if (bearing > int'(cfg_deadband)) return step;
      if (bearing < -int'(cfg_deadband)) return -step;
      return 0;
   endfunction

   function automatic pose_result_type advance_pose(input logic [3:0] mode, input logic seen,
                                                    input bearing_type bearing,
                                                    input range_type range_mm,
                                                    input logic snap);
      pose_result_type r;
      int yaw_sum;
      int brg;
      int rng;
      r = '0;
      brg = bearing;
      rng = range_mm;
      yaw_sum = pose_yaw;
      case (mode)
         MODE_FAR_LEFT: begin
            pose_yaw = yaw_type'(180);  pose_pitch = pitch_type'(50);
         end
         MODE_FAR_MID: begin
            pose_yaw = yaw_type'(0);    pose_pitch = pitch_type'(50);
         end
         MODE_FAR_RIGHT: begin
            pose_yaw = yaw_type'(-180); pose_pitch = pitch_type'(50);
         end
         MODE_FAR_RIGHT_BACK: begin
            pose_yaw = yaw_type'(-270); pose_pitch = pitch_type'(50);
         end
         MODE_FAR_LEFT_BACK: begin
            pose_yaw = yaw_type'(270);  pose_pitch = pitch_type'(50);
         end
         MODE_CLOSE_LEFT: begin
            pose_yaw = yaw_type'(180);  pose_pitch = pitch_type'(110);
         end
         MODE_CLOSE_MID: begin
            pose_yaw = yaw_type'(0);    pose_pitch = pitch_type'(120);
         end
         MODE_CLOSE_RIGHT: begin
            pose_yaw = yaw_type'(-180); pose_pitch = pitch_type'(110);
         end
         MODE_CLOSE_RIGHT_BACK: begin
            pose_yaw = yaw_type'(-270); pose_pitch = pitch_type'(110);
         end
         MODE_CLOSE_LEFT_BACK: begin
            pose_yaw = yaw_type'(270);  pose_pitch = pitch_type'(110);
         end
         MODE_TRACK_HORIZ: begin
            pose_yaw = yaw_type'(limit_yaw(yaw_sum + bearing_step(brg, seen, HorizStep),
                                           HorizYawLimit));
         end
         MODE_TRACK_BOTH: begin
            if (snap) begin
               yaw_sum = yaw_sum + brg;
               r.snap_consumed = 1'b1;
            end else begin
               yaw_sum = yaw_sum + bearing_step(brg, seen, BothStep);
            end
            pose_yaw = yaw_type'(limit_yaw(yaw_sum, BothYawLimit));
            // Far is tested first, so it wins when the thresholds overlap.
            if (seen && rng > int'(cfg_far_mm))
               pose_pitch = pitch_type'(FarPitch);
            else if (seen && rng >= 0 && rng <= int'(cfg_near_mm))
               pose_pitch = pitch_type'(NearPitch);
         end
         default: ;  // Vertical track and the unused codes hold the pose.
      endcase
      r.yaw = pose_yaw;
      r.pitch = pose_pitch;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      pose_result_type want;
      pose_result_type got;
      if (reset) begin
         expected_poses.delete();
         pose_yaw = '0;
         pose_pitch = '0;
         cfg_deadband = DeadbandReset;
         cfg_far_mm = FarRangeReset;
         cfg_near_mm = NearRangeReset;
      end else begin
         // An item taken at this edge still sees the thresholds from before any write here.
         if (req_tvalid && req_tready) begin
            want = advance_pose(req_tuser[3:0], req_tuser[4], bearing_type'(req_tdata[9:0]),
                                range_type'(req_tdata[25:10]), req_tdata[26]);
            expected_poses = {expected_poses, want};
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DEADBAND:   cfg_deadband = csr_wdata[DbWidth-1:0];
               CSR_FAR_RANGE:  cfg_far_mm = csr_wdata[ThrWidth-1:0];
               CSR_NEAR_RANGE: cfg_near_mm = csr_wdata[ThrWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = pose_result_type'(rsp_tdata);
            if (expected_poses.size() == 0) begin
               $error("result with no pose expected: yaw %0d pitch %0d", $signed(got.yaw),
                      got.pitch);
               mismatch_count++;
            end else begin
               want = expected_poses.pop_front();
               results_checked++;
               if (want.snap_consumed) snaps_applied++;
               if ($signed(want.yaw) >= BothYawLimit || $signed(want.yaw) <= -BothYawLimit)
                  limit_hits++;
               if (got.yaw !== want.yaw) begin
                  $error("yaw mismatch: expected %0d, actual %0d", $signed(want.yaw),
                         $signed(got.yaw));
                  mismatch_count++;
               end
               if (got.pitch !== want.pitch) begin
                  $error("pitch mismatch: expected %0d, actual %0d", want.pitch, got.pitch);
                  mismatch_count++;
               end
               if (got.snap_consumed !== want.snap_consumed) begin
                  $error("snap_consumed mismatch: expected %0d, actual %0d",
                         want.snap_consumed, got.snap_consumed);
                  mismatch_count++;
               end
               if (got.pad !== want.pad) begin
                  $error("pad mismatch: expected %0d, actual %0d", want.pad, got.pad);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = expected_poses.size();
   end

endmodule

// ===== dv/tb_pan_tilt_head_tracker_top.sv =====
// Testbench top for the pan/tilt head tracker: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_pan_tilt_head_tracker_top;
   import pthtrk_pkg::*;

   // Mode codes the block treats as hold; they have no name in the package.
   localparam logic [3:0] ModeUnusedLo = 4'd13;
   localparam logic [3:0] ModeUnusedHi = 4'd15;
   // Register index past the end of the list; a write there must change nothing.
   localparam logic [1:0] CsrSpare = 2'd3;
   localparam int LongHoldCycles = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [9:0] ball_bearing, [25:10] ball_range_mm, [26] snap_request, [31:27] zero
   logic [31:0] req_tdata = '0;
   // [3:0] head_mode, [4] ball_seen
   logic [4:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [9:0] yaw, [16:10] pitch, [17] snap_consumed, [23:18] zero
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [14:0] csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int results_checked;
   int snaps_applied;
   int limit_hits;

   // Idle chances in percent per cycle, set per phase by the stimulus.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // Bumped by the stimulus to ask the response side for one long hold-off.
   int hold_requests = 0;
   int ticks_sent = 0;

   // Copies of the thresholds as written, used only to aim the random values.
   logic [DbWidth-1:0]  cur_deadband = DeadbandReset;
   logic [ThrWidth-1:0] cur_far_mm = FarRangeReset;
   logic [ThrWidth-1:0] cur_near_mm = NearRangeReset;

   pan_tilt_head_tracker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pan_tilt_head_tracker_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .snaps_applied   (snaps_applied),
      .limit_hits      (limit_hits)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offers one control tick and holds it until the block takes it. Afterwards the
   // sender may go quiet for a random gap; while quiet, the data lines carry noise so
   // that the block is seen to ignore anything without tvalid.
   task automatic send_tick(input logic [3:0] mode, input logic seen, input int bearing,
                            input int range_mm, input logic snap);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= {seen, mode};
      req_tdata  <= {5'b0, snap, range_mm[15:0], bearing[9:0]};
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= 5'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering ticks and waits until every predicted pose has come back. The
   // first edge lets the checker count a tick taken at the edge we resumed on; the
   // result is registered after its tick, and the closing edges leave the block idle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (2) @(posedge clock);
   endtask

   // One register write per edge; the enable stays high across back-to-back writes
   // and the caller drops it once the whole setting is in.
   task automatic write_csr(input logic [1:0] index, input logic [14:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_DEADBAND:   cur_deadband = value[DbWidth-1:0];
         CSR_FAR_RANGE:  cur_far_mm = value;
         CSR_NEAR_RANGE: cur_near_mm = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Threshold settings, one per phase. The first phase keeps the reset values, the
   // next ones hit the extremes: all zero, full scale with the deadband register's
   // upper bits written as ones, far below near, and two random ones.
   task automatic apply_setting(input int phase);
      int near_mm;
      case (phase)
         1: begin
            write_csr(CSR_DEADBAND, 15'd0);
            write_csr(CSR_FAR_RANGE, 15'd0);
            write_csr(CSR_NEAR_RANGE, 15'd0);
         end
         2: begin
            write_csr(CSR_DEADBAND, 15'h7FFF);
            write_csr(CSR_FAR_RANGE, 15'h7FFF);
            write_csr(CSR_NEAR_RANGE, 15'h7FFF);
         end
         3: begin
            write_csr(CSR_DEADBAND, 15'd360);
            write_csr(CSR_FAR_RANGE, 15'd500);
            write_csr(CSR_NEAR_RANGE, 15'd2000);
            write_csr(CsrSpare, 15'($urandom));
         end
         4: begin
            write_csr(CSR_DEADBAND, 15'($urandom_range(0, 400)));
            write_csr(CSR_FAR_RANGE, 15'($urandom));
            write_csr(CSR_NEAR_RANGE, 15'($urandom));
         end
         default: begin
            near_mm = $urandom_range(200, 3000);
            write_csr(CSR_DEADBAND, 15'($urandom_range(0, 40)));
            write_csr(CSR_NEAR_RANGE, 15'(near_mm));
            write_csr(CSR_FAR_RANGE, 15'(near_mm + $urandom_range(0, 500)));
         end
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Hand-picked ticks at the reset thresholds (deadband 20, far 1200, near 1000).
   task automatic directed_ticks();
      int m;
      // Every preset pose in turn; the last one leaves yaw at +270.
      for (m = MODE_FAR_LEFT; m <= MODE_CLOSE_LEFT_BACK; m++)
         send_tick(m[3:0], m[0], 0, 0, 1'b0);
      // Horizontal tracking at full bearing cannot push past its limit.
      send_tick(MODE_TRACK_HORIZ, 1'b1, 360, 0, 1'b0);
      // A snap applies even with no ball in view, here by the most negative bearing.
      send_tick(MODE_TRACK_BOTH, 1'b0, -512, 0, 1'b1);
      // A snap by the largest bearing overshoots and clamps; maximum range goes far.
      send_tick(MODE_TRACK_BOTH, 1'b1, 511, 32767, 1'b1);
      // A bearing equal to the deadband does not step; a range at near goes near.
      send_tick(MODE_TRACK_BOTH, 1'b1, 20, 1000, 1'b0);
      // Just past the deadband steps by half a degree; a range between holds pitch.
      send_tick(MODE_TRACK_BOTH, 1'b1, -21, 1001, 1'b0);
      // The most negative range is invalid and holds pitch.
      send_tick(MODE_TRACK_BOTH, 1'b1, 0, -32768, 1'b0);
      send_tick(MODE_TRACK_BOTH, 1'b1, 0, 1201, 1'b0);
      send_tick(MODE_TRACK_BOTH, 1'b1, 0, 0, 1'b0);
      // A range exactly at the far threshold is not far.
      send_tick(MODE_TRACK_BOTH, 1'b1, 0, 1200, 1'b0);
      // Without the ball horizontal tracking holds, and a snap there is ignored.
      send_tick(MODE_TRACK_HORIZ, 1'b0, 360, 0, 1'b1);
      // Vertical track and the unused codes hold everything.
      send_tick(MODE_TRACK_VERT, 1'b1, 300, 100, 1'b1);
      send_tick(ModeUnusedLo, 1'b1, 300, 100, 1'b1);
      // Drive the yaw to the negative limits of both tracking modes.
      send_tick(MODE_FAR_RIGHT_BACK, 1'b0, 0, 0, 1'b0);
      send_tick(MODE_TRACK_HORIZ, 1'b1, -360, 0, 1'b0);
      send_tick(MODE_TRACK_BOTH, 1'b1, -100, 32767, 1'b0);
   endtask

   // Random ticks in runs. Tracking runs keep the bearing on one side so that the yaw
   // walks toward its limits; presets and unused codes are mixed in as single ticks,
   // vertical-track holds as short runs. Bearings and ranges cluster around the current
   // thresholds, with a share of full-width noise so that every bit of both fields toggles.
   task automatic run_random(input int count);
      int left;
      int run_len;
      int pick;
      int dir;
      int k;
      int bearing;
      int range_mm;
      logic [3:0] mode;
      logic seen;
      logic snap;
      left = count;
      while (left > 0) begin
         pick = $urandom_range(99);
         dir = ($urandom_range(1) == 1) ? 1 : -1;
         run_len = $urandom_range(4, 30);
         if (pick < 14) begin
            mode = 4'($urandom_range(MODE_FAR_LEFT, MODE_CLOSE_LEFT_BACK));
            run_len = 1;
         end else if (pick < 44) begin
            mode = MODE_TRACK_HORIZ;
         end else if (pick < 84) begin
            mode = MODE_TRACK_BOTH;
         end else if (pick < 92) begin
            mode = MODE_TRACK_VERT;
            run_len = $urandom_range(1, 3);
         end else begin
            mode = 4'($urandom_range(ModeUnusedLo, ModeUnusedHi));
            run_len = 1;
         end
         if (run_len > left) run_len = left;
         for (k = 0; k < run_len; k++) begin
            pick = $urandom_range(99);
            if (pick < 65)
               bearing = dir * int'($urandom_range(0, 360));
            else if (pick < 85)
               bearing = dir * (int'(cur_deadband) + int'($urandom_range(0, 2)) - 1);
            else
               bearing = $urandom;
            pick = $urandom_range(99);
            if (pick < 35)
               range_mm = $urandom;
            else if (pick < 55)
               range_mm = int'(cur_far_mm) + int'($urandom_range(0, 2)) - 1;
            else if (pick < 75)
               range_mm = int'(cur_near_mm) + int'($urandom_range(0, 2)) - 1;
            else
               range_mm = $urandom_range(0, 2500);
            seen = ($urandom_range(99) < 85);
            snap = ($urandom_range(99) < 12);
            send_tick(mode, seen, bearing, range_mm, snap);
         end
         left = left - run_len;
      end
   endtask

   // Response side. Normally it stalls at random per cycle; when asked, it holds off
   // for a long stretch counted here, so the block's single result slot fills and
   // the request side stalls while the sender keeps offering.
   initial begin : response_sink
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left = LongHoldCycles;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Six phases, each under its own threshold setting, written only while the block
   // is idle. The first two phases have a lazy receiver, the next two a lazy sender,
   // and the last two run at full rate on both sides.
   initial begin : stimulus
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < 6; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 31;
            recv_idle_pct = 68;
         end else if (phase < 4) begin
            send_idle_pct = 68;
            recv_idle_pct = 31;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase > 0) begin
            drain_results();
            apply_setting(phase);
         end
         if (phase == 0) begin
            directed_ticks();
            run_random(115);
         end else if (phase == 1) begin
            run_random(70);
            hold_requests <= hold_requests + 1;
            run_random(70);
         end else if (phase == 3) begin
            // The sender pauses mid-phase until every result is back.
            run_random(70);
            drain_results();
            run_random(70);
         end else begin
            run_random(140);
         end
      end
      drain_results();
      $display("Sent %0d ticks under six threshold settings: reset values, all zero,",
               ticks_sent);
      $display("full scale, inverted and random; %0d poses checked, %0d snaps, %0d at a limit.",
               results_checked, snaps_applied, limit_hits);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // The watchdog leaves the slowest correct run a wide margin before declaring the block hung.
   initial begin : watchdog
      #2_500_000;
      $display("Timed out with %0d poses still expected.", pending_count);
      $display("Regression FAIL");
      $finish;
   end

endmodule
